// ===== design/srpg_pkg.sv =====
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types, constants and ROM helpers for the scan-line reticule pulse
// generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

    // Field widths
    localparam int TICK_W  = 16;
    localparam int X_W     = 13;
    localparam int LINE_W  = 10;
    localparam int ROW_W   = 8;
    localparam int HW_W    = 8;
    localparam int ACT_W   = 2;
    localparam int GUN_W   = 2;

    // Parameter defaults
    localparam int DEF_RETICULE_LINES      = 14;
    localparam int DEF_RETICULE_HALF_WIDTH = 75;
    localparam int DEF_LOGO_ROWS           = 200;
    localparam int DEF_TEXT_ROWS           = 80;

    // Fixed line geometry
    localparam int LOGO_TOP_LINE = 49;
    localparam int TEXT_TOP_LINE = 105;
    localparam logic [LINE_W-1:0] LINE_MAX = 10'd1023;
    localparam logic [X_W-1:0]    X_RESET  = 13'd320;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_PLAYER      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATE_GUNS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOGO_ON         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ON         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VSYNC_THRESHOLD = 3'd4;
    localparam logic [TICK_W-1:0]    VSYNC_THRESHOLD_RST = 16'd1280;

    // Command codes
    localparam logic CMD_SYNC = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE  = 2'd0,
        ACT_LOGO  = 2'd1,
        ACT_TEXT  = 2'd2,
        ACT_PULSE = 2'd3
    } t_action;

    typedef enum logic [GUN_W-1:0] {
        GUN_NONE = 2'd0,
        GUN_ONE  = 2'd1,
        GUN_TWO  = 2'd2
    } t_gun;

    typedef struct packed {
        logic              command;
        logic [TICK_W-1:0] sync_ticks;
        logic              player;
        logic [X_W-1:0]    x_position;
        logic [LINE_W-1:0] start_line;
        logic              hide;
    } t_in_item;

    typedef struct packed {
        t_action           action;
        logic [ROW_W-1:0]  row_index;
        logic [X_W-1:0]    pulse_delay;
        logic [HW_W-1:0]   pulse_width;
        t_gun              gun_target;
        logic [LINE_W-1:0] line_number;
    } t_out_item;

    typedef struct packed {
        logic              two_player;
        logic              separate_guns;
        logic              logo_on;
        logic              text_on;
        logic [TICK_W-1:0] vsync_threshold;
    } t_cfg;

    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [LINE_W-1:0] first_line;
        logic              hidden;
    } t_ret;

    // Elaboration-time integer square root (bitwise method)
    function automatic int isqrt(int value);
        int v;
        int root;
        int bitv;
        v    = value;
        root = 0;
        for (int k = 15; k >= 0; k--) begin
            bitv = 1 << (2 * k);
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
        end
        return root;
    endfunction

    function automatic int line_dist(int n, int i);
        int twice;
        twice = 2 * i;
        return (twice >= n - 1) ? (twice - (n - 1)) : ((n - 1) - twice);
    endfunction

    // Circle numerator; divide by the line count at the use site
    function automatic int circle_num(int w, int n, int i);
        int d;
        d = line_dist(n, i);
        return isqrt(w * w * (n * n - d * d));
    endfunction

    // Diamond numerator; divide by the line count at the use site
    function automatic int diamond_num(int w, int n, int i);
        int d;
        d = line_dist(n, i);
        return w * (n - d);
    endfunction

endpackage

// ===== design/srpg_apb.sv =====
// ----------------------------------------------------------------------------
// srpg_apb
// APB-style configuration registers: mode bits and vsync threshold.
// ----------------------------------------------------------------------------
module srpg_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srpg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [srpg_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [srpg_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output srpg_pkg::t_cfg                 o_cfg
);
    import srpg_pkg::*;

    t_cfg                 r_cfg;
    logic [CFG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[CFG_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.two_player      <= 1'b0;
            r_cfg.separate_guns   <= 1'b1;
            r_cfg.logo_on         <= 1'b1;
            r_cfg.text_on         <= 1'b1;
            r_cfg.vsync_threshold <= VSYNC_THRESHOLD_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TWO_PLAYER:      r_cfg.two_player      <= pwdata[0];
                REG_SEPARATE_GUNS:   r_cfg.separate_guns   <= pwdata[0];
                REG_LOGO_ON:         r_cfg.logo_on         <= pwdata[0];
                REG_TEXT_ON:         r_cfg.text_on         <= pwdata[0];
                REG_VSYNC_THRESHOLD: r_cfg.vsync_threshold <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_TWO_PLAYER:      prdata[0] = r_cfg.two_player;
            REG_SEPARATE_GUNS:   prdata[0] = r_cfg.separate_guns;
            REG_LOGO_ON:         prdata[0] = r_cfg.logo_on;
            REG_TEXT_ON:         prdata[0] = r_cfg.text_on;
            REG_VSYNC_THRESHOLD: prdata[TICK_W-1:0] = r_cfg.vsync_threshold;
            default: ;
        endcase
    end

endmodule

// ===== design/srpg_decode.sv =====
// ----------------------------------------------------------------------------
// srpg_decode
// Line decode: logo band, text band or reticule pulse for one scan line,
// with the circle and diamond half-width ROMs.
// ----------------------------------------------------------------------------
module srpg_decode #(
    parameter int RETICULE_LINES      = srpg_pkg::DEF_RETICULE_LINES,
    parameter int RETICULE_HALF_WIDTH = srpg_pkg::DEF_RETICULE_HALF_WIDTH,
    parameter int LOGO_ROWS           = srpg_pkg::DEF_LOGO_ROWS,
    parameter int TEXT_ROWS           = srpg_pkg::DEF_TEXT_ROWS
) (
    input  logic [srpg_pkg::LINE_W-1:0] i_line,
    input  logic                        i_vsync,
    input  logic                        i_pl,
    input  srpg_pkg::t_ret              i_ret,
    input  srpg_pkg::t_cfg              i_cfg,
    output srpg_pkg::t_out_item         o_res
);
    import srpg_pkg::*;

    localparam int OFF_W    = $clog2(RETICULE_LINES);
    localparam int ROM_D    = 2 ** OFF_W;
    localparam int LOGO_END = LOGO_TOP_LINE + LOGO_ROWS;
    localparam int TEXT_END = TEXT_TOP_LINE + TEXT_ROWS;

    logic [HW_W-1:0] w_circle  [ROM_D];
    logic [HW_W-1:0] w_diamond [ROM_D];

    for (genvar gi = 0; gi < ROM_D; gi++) begin : g_rom
        if (gi < RETICULE_LINES) begin : g_used
            localparam int CIRC =
                circle_num(RETICULE_HALF_WIDTH, RETICULE_LINES, gi) / RETICULE_LINES;
            localparam int DIAM =
                diamond_num(RETICULE_HALF_WIDTH, RETICULE_LINES, gi) / RETICULE_LINES;
            assign w_circle[gi]  = HW_W'(CIRC);
            assign w_diamond[gi] = HW_W'(DIAM);
        end else begin : g_pad
            assign w_circle[gi]  = '0;
            assign w_diamond[gi] = '0;
        end
    end

    logic [LINE_W:0]    w_line_x;
    logic [LINE_W:0]    w_logo_off;
    logic [LINE_W:0]    w_text_off;
    logic [LINE_W:0]    w_ret_off;
    logic               w_in_logo;
    logic               w_in_text;
    logic               w_in_ret;
    logic [OFF_W-1:0]   w_rom_idx;
    logic [HW_W-1:0]    w_hw;
    logic [X_W-1:0]     w_hw_x;

    assign w_line_x   = {1'b0, i_line};
    assign w_logo_off = w_line_x - (LINE_W+1)'(LOGO_TOP_LINE);
    assign w_text_off = w_line_x - (LINE_W+1)'(TEXT_TOP_LINE);
    // borrow bit set means the line lies before the reticule start
    assign w_ret_off  = w_line_x - {1'b0, i_ret.first_line};

    assign w_in_logo = i_cfg.logo_on
                    && (w_line_x >= (LINE_W+1)'(LOGO_TOP_LINE))
                    && (w_line_x <  (LINE_W+1)'(LOGO_END));
    assign w_in_text = i_cfg.text_on
                    && (w_line_x >= (LINE_W+1)'(TEXT_TOP_LINE))
                    && (w_line_x <  (LINE_W+1)'(TEXT_END));
    assign w_in_ret  = !i_ret.hidden && !w_ret_off[LINE_W]
                    && (w_ret_off < (LINE_W+1)'(RETICULE_LINES));

    assign w_rom_idx = w_ret_off[OFF_W-1:0];
    assign w_hw      = i_pl ? w_diamond[w_rom_idx] : w_circle[w_rom_idx];
    assign w_hw_x    = {{(X_W-HW_W){1'b0}}, w_hw};

    always_comb begin
        o_res = '0;
        if (!i_vsync) begin
            o_res.line_number = i_line;
            if (w_in_logo) begin
                o_res.action    = ACT_LOGO;
                o_res.row_index = w_logo_off[ROW_W-1:0];
            end else if (w_in_text) begin
                o_res.action    = ACT_TEXT;
                o_res.row_index = w_text_off[ROW_W-1:0];
            end else if (w_in_ret) begin
                o_res.action      = ACT_PULSE;
                o_res.row_index   = w_ret_off[ROW_W-1:0];
                o_res.pulse_delay = (i_ret.x > w_hw_x) ? (i_ret.x - w_hw_x) : '0;
                o_res.pulse_width = {w_hw[HW_W-2:0], 1'b0};
                o_res.gun_target  = (i_pl && i_cfg.separate_guns) ? GUN_TWO : GUN_ONE;
            end
        end
    end

endmodule

// ===== design/scanline_reticule_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// scanline_reticule_pulse_generator
// Per sync pulse, decides what the coming scan line carries: logo row, text
// row or a reticule pulse with delay, width and gun.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//   cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One transaction is taken per cycle while o_in_ready is high; a sync
// transaction's result passes through the input register, then the result
// register, with combinational decode between the two registers. A sync
// transaction waits in the input register while a result is held, which drops
// o_in_ready. A set-reticule transaction yields no result and passes even
// while the result register is stalled. Synchronous active-low reset restores
// the line counter, reticule state and configuration to their reset values;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module scanline_reticule_pulse_generator #(
    parameter int RETICULE_LINES      = srpg_pkg::DEF_RETICULE_LINES,
    parameter int RETICULE_HALF_WIDTH = srpg_pkg::DEF_RETICULE_HALF_WIDTH,
    parameter int LOGO_ROWS           = srpg_pkg::DEF_LOGO_ROWS,
    parameter int TEXT_ROWS           = srpg_pkg::DEF_TEXT_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  srpg_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output srpg_pkg::t_out_item             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srpg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [srpg_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [srpg_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import srpg_pkg::*;

    t_cfg              w_cfg;
    t_in_item          r_in;
    logic              r_in_valid;
    t_out_item         r_out;
    logic              r_out_valid;
    logic [LINE_W-1:0] r_line;
    logic [X_W-1:0]    r_ret_x     [2];
    logic [LINE_W-1:0] r_ret_first [2];
    logic              r_ret_hid   [2];

    logic              w_adv;
    logic              w_is_sync;
    logic              w_vsync;
    logic              w_pl;
    t_ret              w_ret;
    t_out_item         w_res;

    srpg_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_is_sync = (r_in.command == CMD_SYNC);
    assign w_vsync   = (r_in.sync_ticks > w_cfg.vsync_threshold);
    assign w_pl      = r_line[0] & w_cfg.two_player;

    assign w_ret.x          = r_ret_x[w_pl];
    assign w_ret.first_line = r_ret_first[w_pl];
    assign w_ret.hidden     = r_ret_hid[w_pl];

    srpg_decode #(
        .RETICULE_LINES      (RETICULE_LINES),
        .RETICULE_HALF_WIDTH (RETICULE_HALF_WIDTH),
        .LOGO_ROWS           (LOGO_ROWS),
        .TEXT_ROWS           (TEXT_ROWS)
    ) u_decode (
        .i_line  (r_line),
        .i_vsync (w_vsync),
        .i_pl    (w_pl),
        .i_ret   (w_ret),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // set transactions never wait on the result register
    assign w_adv      = r_in_valid && (!w_is_sync || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_is_sync) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_is_sync) begin
            r_out <= w_res;
        end
    end

    // line counter: clear on vsync, saturate at LINE_MAX
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else if (w_adv && w_is_sync) begin
            if (w_vsync) begin
                r_line <= '0;
            end else if (r_line != LINE_MAX) begin
                r_line <= r_line + LINE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 2; p++) begin
                r_ret_x[p]     <= X_RESET;
                r_ret_first[p] <= '0;
                r_ret_hid[p]   <= 1'b1;
            end
        end else if (w_adv && !w_is_sync) begin
            r_ret_x[r_in.player]     <= r_in.x_position;
            r_ret_first[r_in.player] <= r_in.start_line;
            r_ret_hid[r_in.player]   <= r_in.hide;
        end
    end

endmodule
